FILE: sv/dhglcd_pkg.sv
package dhglcd_pkg;

	// Geometry of one half
	localparam int PAGE_COUNT   = 8;
	localparam int COLUMN_COUNT = 64;
	localparam int PAGE_W       = 3;
	localparam int COL_W        = 6;
	localparam int LINE_W       = 6;
	localparam int BANK_AW      = PAGE_W + COL_W;
	localparam int BANK_DEPTH   = 1 << BANK_AW;

	// Request codes
	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_STATUS  = 2'd1;
	localparam logic [1:0] REQ_FETCH   = 2'd2;
	localparam logic [1:0] REQ_IGNORED = 2'd3;

	// Command byte patterns
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h3E;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h3F;
	localparam logic [7:0] CMD_SET_COLUMN  = 8'h40;
	localparam logic [7:0] CMD_SET_PAGE    = 8'hB8;
	localparam logic [7:0] CMD_SET_LINE    = 8'hC0;

	// Status byte with the display-off flag set
	localparam logic [7:0] STATUS_OFF = 8'h20;

	typedef struct packed {
		logic [1:0]        req_type;
		logic              select_left_n;
		logic              select_right_n;
		logic              reg_select;
		logic [7:0]        bus_data;
		logic              fetch_half;
		logic [PAGE_W-1:0] fetch_page;
		logic [COL_W-1:0]  fetch_column;
	} request_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              display_enabled;
		logic [LINE_W-1:0] scroll_line;
	} result_t;

endpackage

FILE: sv/dual_half_graphic_lcd_controller.sv
// A status read with a half selected, or a fetch, gives its result in the cycle after its transfer;
// a bus write gives no result and takes effect at its transfer edge.
// Throughput: one request per cycle; busy stays low, since the display RAM
// banks have one read and one write port each.
// Reset (arst_n low): pointers, start lines and display-on flags clear, the
// result strobe drops; display RAM contents stay undefined until written.
module dual_half_graphic_lcd_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dhglcd_pkg::request_t  request,
	output logic                  result_valid,
	output dhglcd_pkg::result_t   result
);

	logic                          accept;
	logic [1:0]                    sel;
	logic [dhglcd_pkg::PAGE_W-1:0] page_q [2];
	logic [dhglcd_pkg::COL_W-1:0]  col_q  [2];
	logic [dhglcd_pkg::LINE_W-1:0] line_q [2];
	logic                          on_q   [2];
	logic [1:0]                    bank_we;
	logic [dhglcd_pkg::BANK_AW-1:0] wr_addr [2];
	logic [dhglcd_pkg::BANK_AW-1:0] rd_addr;
	logic [7:0]                    mem_left  [dhglcd_pkg::BANK_DEPTH];
	logic [7:0]                    mem_right [dhglcd_pkg::BANK_DEPTH];
	logic [7:0]                    rd_left_s1;
	logic [7:0]                    rd_right_s1;
	logic                          is_write;
	logic                          is_status;
	logic                          is_fetch;
	logic                          has_result;
	logic                          src_half;
	logic                          in_range;
	logic                          valid_s1;
	logic                          fetch_s1;
	logic                          zero_s1;
	logic                          half_s1;
	logic                          on_s1;
	logic [dhglcd_pkg::LINE_W-1:0] line_s1;
	logic [7:0]                    cmd;
	logic [dhglcd_pkg::COL_W:0]    col_next [2];
	logic [dhglcd_pkg::COL_W:0]    col_cmd;
	logic [dhglcd_pkg::PAGE_W:0]   page_cmd;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign sel    = {!request.select_right_n, !request.select_left_n};
	assign cmd    = request.bus_data;

	// Decode the request
	always_comb begin
		is_write  = request.req_type == dhglcd_pkg::REQ_WRITE;
		is_status = request.req_type == dhglcd_pkg::REQ_STATUS;
		is_fetch  = request.req_type == dhglcd_pkg::REQ_FETCH;
		src_half  = is_fetch ? request.fetch_half : !sel[0];
		has_result = is_fetch || (is_status && (sel[0] || sel[1]));
		in_range  = ({1'b0, request.fetch_page} <
				(dhglcd_pkg::PAGE_W+1)'(dhglcd_pkg::PAGE_COUNT)) &&
			({1'b0, request.fetch_column} <
				(dhglcd_pkg::COL_W+1)'(dhglcd_pkg::COLUMN_COUNT));
		rd_addr   = {request.fetch_page, request.fetch_column};
		// saturate command arguments to the geometry
		col_cmd   = {1'b0, cmd[dhglcd_pkg::COL_W-1:0]};
		if (col_cmd >= (dhglcd_pkg::COL_W+1)'(dhglcd_pkg::COLUMN_COUNT))
			col_cmd = (dhglcd_pkg::COL_W+1)'(dhglcd_pkg::COLUMN_COUNT - 1);
		page_cmd  = {1'b0, cmd[dhglcd_pkg::PAGE_W-1:0]};
		if (page_cmd >= (dhglcd_pkg::PAGE_W+1)'(dhglcd_pkg::PAGE_COUNT))
			page_cmd = (dhglcd_pkg::PAGE_W+1)'(dhglcd_pkg::PAGE_COUNT - 1);
		for (int h = 0; h < 2; h++) begin
			bank_we[h]  = accept && is_write && request.reg_select && sel[h];
			wr_addr[h]  = {page_q[h], col_q[h]};
			col_next[h] = {1'b0, col_q[h]} + 1'b1;
			if (col_next[h] >= (dhglcd_pkg::COL_W+1)'(dhglcd_pkg::COLUMN_COUNT))
				col_next[h] = '0;
		end
	end

	// Update the pointers and flags of each selected half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < 2; h++) begin
				page_q[h] <= '0;
				col_q[h]  <= '0;
				line_q[h] <= '0;
				on_q[h]   <= 1'b0;
			end
		end else if (accept && is_write) begin
			for (int h = 0; h < 2; h++) begin
				if (sel[h]) begin
					if (request.reg_select) begin
						col_q[h] <= col_next[h][dhglcd_pkg::COL_W-1:0];
					end else if ((cmd & 8'hFE) == dhglcd_pkg::CMD_DISPLAY_OFF) begin
						on_q[h] <= cmd == dhglcd_pkg::CMD_DISPLAY_ON;
					end else if ((cmd & 8'hC0) == dhglcd_pkg::CMD_SET_COLUMN) begin
						col_q[h] <= col_cmd[dhglcd_pkg::COL_W-1:0];
					end else if ((cmd & 8'hF8) == dhglcd_pkg::CMD_SET_PAGE) begin
						page_q[h] <= page_cmd[dhglcd_pkg::PAGE_W-1:0];
					end else if ((cmd & 8'hC0) == dhglcd_pkg::CMD_SET_LINE) begin
						line_q[h] <= cmd[dhglcd_pkg::LINE_W-1:0];
					end
				end
			end
		end
	end

	// Left display RAM bank: write at the current pointer, read for fetch
	always_ff @(posedge clk) begin
		if (bank_we[0])
			mem_left[wr_addr[0]] <= request.bus_data;
		rd_left_s1 <= mem_left[rd_addr];
	end

	// Right display RAM bank
	always_ff @(posedge clk) begin
		if (bank_we[1])
			mem_right[wr_addr[1]] <= request.bus_data;
		rd_right_s1 <= mem_right[rd_addr];
	end

	// Hold the strobe for one cycle after a transfer that answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept && has_result;
	end

	// Capture the result fields alongside the RAM read
	always_ff @(posedge clk) begin
		fetch_s1 <= is_fetch;
		zero_s1  <= !in_range;
		half_s1  <= src_half;
		on_s1    <= on_q[src_half];
		line_s1  <= line_q[src_half];
	end

	// Drive the result
	always_comb begin
		result_valid           = valid_s1;
		result.display_enabled = on_s1;
		result.scroll_line     = line_s1;
		if (!fetch_s1)
			result.read_data = on_s1 ? 8'h00 : dhglcd_pkg::STATUS_OFF;
		else if (zero_s1)
			result.read_data = 8'h00;
		else
			result.read_data = half_s1 ? rd_right_s1 : rd_left_s1;
	end

endmodule

FILE: sv/dhglcd_checker.sv
module dhglcd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input dhglcd_pkg::request_t request,
	input logic                 result_valid,
	input dhglcd_pkg::result_t  result
);

	// A fetch transfer always answers in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.req_type == dhglcd_pkg::REQ_FETCH |=> result_valid)
		else $error("fetch gave no result");

	// A bus write never answers
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.req_type == dhglcd_pkg::REQ_WRITE |=> !result_valid)
		else $error("bus write gave a result");

	// A result follows only a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy))
		else $error("result without a transfer");

	// Status byte: busy clear, off flag mirrors the display-on field
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(request.req_type == dhglcd_pkg::REQ_STATUS) |->
			result.read_data[7] == 1'b0 &&
			result.read_data[5] == !result.display_enabled)
		else $error("bad status byte");

endmodule

bind dual_half_graphic_lcd_controller dhglcd_checker u_dhglcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.request      (request),
	.result_valid (result_valid),
	.result       (result)
);

FILE: sim/dual_half_graphic_lcd_controller_tb.sv
module dual_half_graphic_lcd_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int RAM_DEPTH = 2 * dhglcd_pkg::BANK_DEPTH;
	localparam int REQ_BITS = $bits(dhglcd_pkg::request_t);

	typedef struct {
		dhglcd_pkg::request_t rq;
		int                   idle_pct;
	} pending_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start = 1'b0;
	logic                 busy;
	dhglcd_pkg::request_t request = '0;
	logic                 result_valid;
	dhglcd_pkg::result_t  result;

	dual_half_graphic_lcd_controller uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result)
	);

	// Requests waiting to be driven, and reads waiting for their answer
	pending_item_t       pending_items[$];
	dhglcd_pkg::result_t expected_reads[$];

	// Shadow of the panel state
	logic [7:0]                    shadow_ram [0:RAM_DEPTH-1];
	logic [dhglcd_pkg::PAGE_W-1:0] shadow_page [2] = '{default: '0};
	logic [dhglcd_pkg::COL_W-1:0]  shadow_col [2] = '{default: '0};
	logic [dhglcd_pkg::LINE_W-1:0] shadow_line [2] = '{default: '0};
	logic                          shadow_on [2] = '{default: 1'b0};

	// Pointer tracking on the generating side, so fetches only hit written bytes
	logic [dhglcd_pkg::PAGE_W-1:0] gen_page [2];
	logic [dhglcd_pkg::COL_W-1:0]  gen_col [2];
	bit                            gen_written [0:RAM_DEPTH-1];
	int                            written_list[$];

	bit xfer_done;
	int mismatch_count;
	int cycle_count;

	function automatic dhglcd_pkg::request_t build_request(logic [1:0] kind, logic l_n,
			logic r_n, logic rs, logic [7:0] b, logic fh,
			logic [dhglcd_pkg::PAGE_W-1:0] fp, logic [dhglcd_pkg::COL_W-1:0] fc);
		dhglcd_pkg::request_t rq;
		rq = '{kind, l_n, r_n, rs, b, fh, fp, fc};
		return rq;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Apply one transferred request to the shadow state and queue any read answer
	task automatic predict_panel_access(input dhglcd_pkg::request_t rq);
		logic                sel_n;
		logic [7:0]          b;
		logic [7:0]          v;
		int                  h;
		int                  idx;
		dhglcd_pkg::result_t r;
		b = rq.bus_data;
		case (rq.req_type)
			dhglcd_pkg::REQ_WRITE: begin
				for (h = 0; h < 2; h++) begin
					sel_n = (h == 0) ? rq.select_left_n : rq.select_right_n;
					if (!sel_n) begin
						if (rq.reg_select) begin
							idx = h * dhglcd_pkg::BANK_DEPTH
								+ int'(shadow_page[h]) * dhglcd_pkg::COLUMN_COUNT
								+ int'(shadow_col[h]);
							shadow_ram[idx] = b;
							shadow_col[h] =
								(int'(shadow_col[h]) + 1 >= dhglcd_pkg::COLUMN_COUNT) ?
								'0 : shadow_col[h] + 1'b1;
						end else if ((b & 8'hFE) == dhglcd_pkg::CMD_DISPLAY_OFF) begin
							shadow_on[h] = b[0];
						end else if ((b & 8'hC0) == dhglcd_pkg::CMD_SET_COLUMN) begin
							shadow_col[h] = (int'(b[5:0]) >= dhglcd_pkg::COLUMN_COUNT) ?
								(dhglcd_pkg::COL_W)'(dhglcd_pkg::COLUMN_COUNT - 1) :
								b[dhglcd_pkg::COL_W-1:0];
						end else if ((b & 8'hF8) == dhglcd_pkg::CMD_SET_PAGE) begin
							shadow_page[h] = (int'(b[2:0]) >= dhglcd_pkg::PAGE_COUNT) ?
								(dhglcd_pkg::PAGE_W)'(dhglcd_pkg::PAGE_COUNT - 1) :
								b[dhglcd_pkg::PAGE_W-1:0];
						end else if ((b & 8'hC0) == dhglcd_pkg::CMD_SET_LINE) begin
							shadow_line[h] = b[5:0];
						end
					end
				end
			end
			dhglcd_pkg::REQ_STATUS: begin
				if (!rq.select_left_n || !rq.select_right_n) begin
					h = !rq.select_left_n ? 0 : 1;
					r.read_data = shadow_on[h] ? 8'h00 : dhglcd_pkg::STATUS_OFF;
					r.display_enabled = shadow_on[h];
					r.scroll_line = shadow_line[h];
					expected_reads.push_back(r);
				end
			end
			dhglcd_pkg::REQ_FETCH: begin
				h = int'(rq.fetch_half);
				v = 8'h00;
				if (int'(rq.fetch_page) < dhglcd_pkg::PAGE_COUNT &&
						int'(rq.fetch_column) < dhglcd_pkg::COLUMN_COUNT)
					v = shadow_ram[h * dhglcd_pkg::BANK_DEPTH
						+ int'(rq.fetch_page) * dhglcd_pkg::COLUMN_COUNT
						+ int'(rq.fetch_column)];
				r.read_data = v;
				r.display_enabled = shadow_on[h];
				r.scroll_line = shadow_line[h];
				expected_reads.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Queue a request and follow the pointers it moves
	task automatic queue_request(input dhglcd_pkg::request_t rq, input int idle_pct);
		pending_item_t it;
		logic          sel_n;
		int            h;
		int            idx;
		it.rq = rq;
		it.idle_pct = idle_pct;
		pending_items.push_back(it);
		if (rq.req_type == dhglcd_pkg::REQ_WRITE) begin
			for (h = 0; h < 2; h++) begin
				sel_n = (h == 0) ? rq.select_left_n : rq.select_right_n;
				if (!sel_n) begin
					if (rq.reg_select) begin
						idx = h * dhglcd_pkg::BANK_DEPTH
							+ int'(gen_page[h]) * dhglcd_pkg::COLUMN_COUNT + int'(gen_col[h]);
						if (!gen_written[idx]) begin
							gen_written[idx] = 1'b1;
							written_list.push_back(idx);
						end
						gen_col[h] = (int'(gen_col[h]) + 1 >= dhglcd_pkg::COLUMN_COUNT) ?
							'0 : gen_col[h] + 1'b1;
					end else if ((rq.bus_data & 8'hC0) == dhglcd_pkg::CMD_SET_COLUMN) begin
						gen_col[h] = (int'(rq.bus_data[5:0]) >= dhglcd_pkg::COLUMN_COUNT) ?
							(dhglcd_pkg::COL_W)'(dhglcd_pkg::COLUMN_COUNT - 1) :
							rq.bus_data[dhglcd_pkg::COL_W-1:0];
					end else if ((rq.bus_data & 8'hF8) == dhglcd_pkg::CMD_SET_PAGE) begin
						gen_page[h] = (int'(rq.bus_data[2:0]) >= dhglcd_pkg::PAGE_COUNT) ?
							(dhglcd_pkg::PAGE_W)'(dhglcd_pkg::PAGE_COUNT - 1) :
							rq.bus_data[dhglcd_pkg::PAGE_W-1:0];
					end
				end
			end
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive the next request at the falling edge once the previous one has transferred
	always @(negedge clk) begin
		pending_item_t nxt;
		if (arst_n && (!start || xfer_done)) begin
			if (pending_items.size() != 0 &&
					$urandom_range(99) >= pending_items[0].idle_pct) begin
				nxt = pending_items.pop_front();
				start <= 1'b1;
				request <= nxt.rq;
			end else begin
				start <= 1'b0;
				request <= dhglcd_pkg::request_t'(REQ_BITS'($urandom));
			end
		end
	end

	// Check results and record transfers at the rising edge
	always @(posedge clk) begin
		dhglcd_pkg::result_t want;
		if (!arst_n) begin
			xfer_done = 1'b0;
		end else begin
			if (result_valid) begin
				if (expected_reads.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h", result));
				end else begin
					want = expected_reads.pop_front();
					if (result.read_data !== want.read_data)
						flag_mismatch($sformatf("read_data %h, wanted %h",
							result.read_data, want.read_data));
					if (result.display_enabled !== want.display_enabled)
						flag_mismatch($sformatf("display_enabled %b, wanted %b",
							result.display_enabled, want.display_enabled));
					if (result.scroll_line !== want.scroll_line)
						flag_mismatch($sformatf("scroll_line %0d, wanted %0d",
							result.scroll_line, want.scroll_line));
				end
			end
			xfer_done = start && !busy;
			if (xfer_done)
				predict_panel_access(request);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int                   random_items;
		int                   idle_pct;
		int                   pick;
		int                   n;
		int                   idx;
		logic                 l_n;
		logic                 r_n;
		dhglcd_pkg::request_t rq;
		int                   phase_idle [4];

		phase_idle = '{0, 49, 0, 19};
		arst_n = 1'b0;
		for (int h = 0; h < 2; h++) begin
			gen_page[h] = '0;
			gen_col[h] = '0;
		end

		// Directed: reset state, every command, wrap of the column, ignored bytes
		queue_request(build_request(dhglcd_pkg::REQ_STATUS, 1'b0, 1'b1, 1'b0, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_STATUS, 1'b1, 1'b0, 1'b0, 8'hFF,
			1'b1, 3'd7, 6'd63), 0);
		queue_request(build_request(dhglcd_pkg::REQ_STATUS, 1'b1, 1'b1, 1'b1, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_IGNORED, 1'b0, 1'b0, 1'b1, 8'hFF,
			1'b1, 3'd7, 6'd63), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0,
			dhglcd_pkg::CMD_DISPLAY_ON, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b1, 1'b0, 8'hFF,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b1, 1'b0, 1'b0,
			dhglcd_pkg::CMD_SET_LINE, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0,
			dhglcd_pkg::CMD_SET_PAGE | 8'h07, 1'b1, 3'd7, 6'd63), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0,
			dhglcd_pkg::CMD_SET_COLUMN | 8'h3F, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b1, 8'hFF,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b1, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b1, 1'b0,
			dhglcd_pkg::CMD_SET_PAGE, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b1, 1'b0,
			dhglcd_pkg::CMD_SET_COLUMN, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b1, 1'b1, 8'hA5,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b1, 1'b1, 1'b1, 8'h5A,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0, 8'h80,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b0, 1'b0, 1'b0, 8'hB0,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_WRITE, 1'b1, 1'b0, 1'b0,
			dhglcd_pkg::CMD_DISPLAY_OFF, 1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_STATUS, 1'b0, 1'b0, 1'b0, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_STATUS, 1'b1, 1'b0, 1'b1, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_FETCH, 1'b0, 1'b0, 1'b1, 8'hFF,
			1'b0, 3'd7, 6'd63), 0);
		queue_request(build_request(dhglcd_pkg::REQ_FETCH, 1'b1, 1'b1, 1'b0, 8'h00,
			1'b1, 3'd7, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_FETCH, 1'b1, 1'b1, 1'b0, 8'h00,
			1'b0, 3'd0, 6'd0), 0);
		queue_request(build_request(dhglcd_pkg::REQ_FETCH, 1'b0, 1'b1, 1'b1, 8'h00,
			1'b1, 3'd7, 6'd63), 0);

		// Random: mostly page/column/data bursts, mixed with reads of written bytes and noise
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			idle_pct = phase_idle[(random_items * 4) / RANDOM_ITEMS];
			pick = $urandom_range(99);
			if (pick < 30) begin
				case ($urandom_range(9))
					0: begin l_n = 1'b1; r_n = 1'b1; end
					1, 2, 3: begin l_n = 1'b0; r_n = 1'b1; end
					4, 5, 6: begin l_n = 1'b1; r_n = 1'b0; end
					default: begin l_n = 1'b0; r_n = 1'b0; end
				endcase
				rq = dhglcd_pkg::request_t'(REQ_BITS'($urandom));
				rq.req_type = dhglcd_pkg::REQ_WRITE;
				rq.select_left_n = l_n;
				rq.select_right_n = r_n;
				rq.reg_select = 1'b0;
				rq.bus_data = dhglcd_pkg::CMD_SET_PAGE |
					8'($urandom_range(dhglcd_pkg::PAGE_COUNT - 1));
				queue_request(rq, idle_pct);
				rq.bus_data = dhglcd_pkg::CMD_SET_COLUMN |
					8'($urandom_range(dhglcd_pkg::COLUMN_COUNT - 1));
				queue_request(rq, idle_pct);
				n = $urandom_range(1, 8);
				rq.reg_select = 1'b1;
				for (int k = 0; k < n; k++) begin
					rq.bus_data = 8'($urandom);
					queue_request(rq, idle_pct);
				end
				random_items += n + 2;
			end else begin
				rq = dhglcd_pkg::request_t'(REQ_BITS'($urandom));
				if (pick < 45) begin
					rq.req_type = dhglcd_pkg::REQ_WRITE;
					rq.reg_select = 1'b0;
					case ($urandom_range(3))
						0: rq.bus_data = dhglcd_pkg::CMD_DISPLAY_OFF | 8'($urandom_range(1));
						1: rq.bus_data = dhglcd_pkg::CMD_SET_LINE | 8'($urandom_range(63));
						default: rq.bus_data = 8'($urandom);
					endcase
				end else if (pick < 60 || (pick < 90 && written_list.size() == 0)) begin
					rq.req_type = dhglcd_pkg::REQ_STATUS;
				end else if (pick < 90) begin
					idx = written_list[$urandom_range(written_list.size() - 1)];
					rq.req_type = dhglcd_pkg::REQ_FETCH;
					rq.fetch_half = 1'(idx / dhglcd_pkg::BANK_DEPTH);
					rq.fetch_page = (dhglcd_pkg::PAGE_W)'((idx % dhglcd_pkg::BANK_DEPTH)
						/ dhglcd_pkg::COLUMN_COUNT);
					rq.fetch_column = (dhglcd_pkg::COL_W)'(idx % dhglcd_pkg::COLUMN_COUNT);
				end else if (pick < 95) begin
					rq.req_type = dhglcd_pkg::REQ_IGNORED;
				end else begin
					rq.req_type = dhglcd_pkg::REQ_WRITE;
					rq.reg_select = 1'b1;
				end
				queue_request(rq, idle_pct);
				random_items++;
			end
		end

		// Hold reset, then release at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every request transferred and every read answered
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || expected_reads.size() != 0);
		repeat (4) @(negedge clk);

		if (mismatch_count == 0 && expected_reads.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
sv/dhglcd_pkg.sv
sv/dual_half_graphic_lcd_controller.sv
sv/dhglcd_checker.sv
sim/dual_half_graphic_lcd_controller_tb.sv
